@@ src/morse_code_keyer_assert.svh @@
// ---------------------------------------------------------------------------
// Assertion macros for the Morse keyer.
// Each macro expects clk and rst in scope.
// ---------------------------------------------------------------------------
`ifndef MORSE_CODE_KEYER_ASSERT_SVH
`define MORSE_CODE_KEYER_ASSERT_SVH

// Same-cycle implication.
`define MCK_ASSERT_SAME(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication.
`define MCK_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ src/mck_pkg.sv @@
`default_nettype none
// ---------------------------------------------------------------------------
// mck_pkg
// Types, constants and the Morse code table shared by the keyer modules.
// ---------------------------------------------------------------------------
package mck_pkg;

  localparam int CHAR_W   = 8;
  localparam int DUR_W    = 6;
  localparam int SHORT_W  = 4;
  localparam int IDX_W    = 6;
  localparam int NCODES   = 36;
  localparam int ADDR_W   = 5;
  localparam int DATA_W   = 32;

  // Register indexes (byte address / 4)
  localparam logic [2:0] REG_DASH       = 3'd0;
  localparam logic [2:0] REG_LETTER_GAP = 3'd1;
  localparam logic [2:0] REG_WORD_GAP   = 3'd2;
  localparam logic [2:0] REG_LINE_GAP   = 3'd3;
  localparam logic [2:0] REG_ACTIVE_LOW = 3'd4;

  // Character codes
  localparam logic [CHAR_W-1:0] CHAR_SPACE   = 8'd32;
  localparam logic [CHAR_W-1:0] CHAR_NEWLINE = 8'd10;
  localparam logic [CHAR_W-1:0] CHAR_LOW_A   = 8'd97;
  localparam logic [CHAR_W-1:0] CHAR_LOW_Z   = 8'd122;
  localparam logic [CHAR_W-1:0] CHAR_ZERO    = 8'd48;
  localparam logic [CHAR_W-1:0] CHAR_NINE    = 8'd57;
  localparam logic [CHAR_W-1:0] DIGIT_OFFSET = 8'd22;  // '0' - 26

  typedef struct packed {
    logic [SHORT_W-1:0] dash_units;
    logic [SHORT_W-1:0] letter_gap_units;
    logic [DUR_W-1:0]   word_gap_units;
    logic [DUR_W-1:0]   line_gap_units;
    logic               active_low;
  } cfg_t;

  // Element count and pattern, MSB first, 1 = dash
  typedef struct packed {
    logic [2:0] len;
    logic [4:0] bits;
  } code_t;

  function automatic code_t code_entry(input logic [IDX_W-1:0] idx);
    code_t c;
    unique case (idx)
      6'd0:  c = '{3'd2, 5'h01};
      6'd1:  c = '{3'd4, 5'h08};
      6'd2:  c = '{3'd4, 5'h0A};
      6'd3:  c = '{3'd3, 5'h04};
      6'd4:  c = '{3'd1, 5'h00};
      6'd5:  c = '{3'd4, 5'h02};
      6'd6:  c = '{3'd3, 5'h06};
      6'd7:  c = '{3'd4, 5'h00};
      6'd8:  c = '{3'd2, 5'h00};
      6'd9:  c = '{3'd4, 5'h07};
      6'd10: c = '{3'd3, 5'h05};
      6'd11: c = '{3'd4, 5'h04};
      6'd12: c = '{3'd2, 5'h03};
      6'd13: c = '{3'd2, 5'h02};
      6'd14: c = '{3'd3, 5'h07};
      6'd15: c = '{3'd4, 5'h06};
      6'd16: c = '{3'd4, 5'h0D};
      6'd17: c = '{3'd3, 5'h02};
      6'd18: c = '{3'd3, 5'h00};
      6'd19: c = '{3'd1, 5'h01};
      6'd20: c = '{3'd3, 5'h01};
      6'd21: c = '{3'd4, 5'h01};
      6'd22: c = '{3'd3, 5'h03};
      6'd23: c = '{3'd4, 5'h09};
      6'd24: c = '{3'd4, 5'h0B};
      6'd25: c = '{3'd4, 5'h0C};
      6'd26: c = '{3'd5, 5'h1F};
      6'd27: c = '{3'd5, 5'h0F};
      6'd28: c = '{3'd5, 5'h07};
      6'd29: c = '{3'd5, 5'h03};
      6'd30: c = '{3'd5, 5'h01};
      6'd31: c = '{3'd5, 5'h00};
      6'd32: c = '{3'd5, 5'h10};
      6'd33: c = '{3'd5, 5'h18};
      6'd34: c = '{3'd5, 5'h1C};
      6'd35: c = '{3'd5, 5'h1E};
      default: c = '{3'd1, 5'h00};
    endcase
    return c;
  endfunction

  // A zero timing value counts as one unit
  function automatic logic [DUR_W-1:0] at_least_one(input logic [DUR_W-1:0] v);
    return (v == '0) ? DUR_W'(1) : v;
  endfunction

endpackage
`default_nettype wire

@@ src/mck_ifs.sv @@
`default_nettype none
// ---------------------------------------------------------------------------
// mck_in_if / mck_out_if
// Valid/ready channels for characters in and LED segments out.
// ---------------------------------------------------------------------------
interface mck_in_if;
  import mck_pkg::*;
  logic              valid;
  logic              ready;
  logic [CHAR_W-1:0] character;
  modport source (output valid, character, input ready);
  modport sink   (input valid, character, output ready);
endinterface

interface mck_out_if;
  import mck_pkg::*;
  logic             valid;
  logic             ready;
  logic             led_level;
  logic [DUR_W-1:0] duration_units;
  logic             last;
  modport source (output valid, led_level, duration_units, last, input ready);
  modport sink   (input valid, led_level, duration_units, last, output ready);
endinterface
`default_nettype wire

@@ src/morse_code_keyer.sv @@
// A letter or digit enters the LETTER state, with its ROM pattern read, at the
// accepting edge, a space or newline the GAP state; segments are registered out
// from that state. One segment leaves per cycle while the output is not stalled;
// the input stays closed until a character's closing segment is registered.
// Reset (rst, synchronous): timing registers return to 3/3/7/21, active low.
`default_nettype none
// ---------------------------------------------------------------------------
// morse_code_keyer
// ASCII to Morse LED segment encoder with an APB configuration port.
// ---------------------------------------------------------------------------
`include "morse_code_keyer_assert.svh"

module morse_code_keyer (
  input  wire logic                       clk,
  input  wire logic                       rst,
  input  wire logic                       psel,
  input  wire logic                       penable,
  input  wire logic                       pwrite,
  input  wire logic [mck_pkg::ADDR_W-1:0] paddr,
  input  wire logic [mck_pkg::DATA_W-1:0] pwdata,
  output logic      [mck_pkg::DATA_W-1:0] prdata,
  output logic                            pready,
  mck_in_if.sink                          chars,
  mck_out_if.source                       segs
);
  import mck_pkg::*;

  cfg_t              cfg;
  logic              rom_rd;
  logic [IDX_W-1:0]  rom_addr;
  code_t             rom_q;

  // Hold timing and polarity; change them only while no character is in flight
  mck_cfg_regs u_cfg (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  // Look up the element pattern; data is registered and valid in the cycle after the accept
  mck_code_rom u_rom (
    .clk  (clk),
    .rd   (rom_rd),
    .addr (rom_addr),
    .q    (rom_q)
  );

  // Classify the character, then advance one segment per free output slot
  mck_seq u_seq (
    .clk      (clk),
    .rst      (rst),
    .cfg      (cfg),
    .chars    (chars),
    .segs     (segs),
    .rom_rd   (rom_rd),
    .rom_addr (rom_addr),
    .rom_q    (rom_q)
  );

  // The closing segment of every character is always an off segment
  `MCK_ASSERT_SAME(a_last_is_off, segs.valid && segs.last, segs.led_level == cfg.active_low, "last segment driven on")
  // No segment has zero length
  `MCK_ASSERT_SAME(a_dur_nonzero, segs.valid, segs.duration_units != '0, "zero-length segment")
  // A space is taken and the input closes until its gap has gone out
  `MCK_ASSERT_NEXT(a_space_busy, chars.valid && chars.ready && chars.character == CHAR_SPACE, !chars.ready, "input open during gap")

endmodule
`default_nettype wire

@@ src/mck_code_rom.sv @@
`default_nettype none
// ---------------------------------------------------------------------------
// mck_code_rom
// Morse pattern table with a registered read port.
// ---------------------------------------------------------------------------
module mck_code_rom (
  input  wire logic                      clk,
  input  wire logic                      rd,
  input  wire logic [mck_pkg::IDX_W-1:0] addr,
  output mck_pkg::code_t                 q
);
  import mck_pkg::*;

  code_t mem [NCODES];

  always_comb begin
    for (int i = 0; i < NCODES; i++) begin
      mem[i] = code_entry(IDX_W'(i));
    end
  end

  always_ff @(posedge clk) begin
    if (rd) begin
      q <= (addr < IDX_W'(NCODES)) ? mem[addr] : code_entry(addr);
    end
  end

endmodule
`default_nettype wire

@@ src/mck_cfg_regs.sv @@
`default_nettype none
// ---------------------------------------------------------------------------
// mck_cfg_regs
// APB register file for timing and polarity.
// ---------------------------------------------------------------------------
module mck_cfg_regs (
  input  wire logic                       clk,
  input  wire logic                       rst,
  input  wire logic                       psel,
  input  wire logic                       penable,
  input  wire logic                       pwrite,
  input  wire logic [mck_pkg::ADDR_W-1:0] paddr,
  input  wire logic [mck_pkg::DATA_W-1:0] pwdata,
  output logic      [mck_pkg::DATA_W-1:0] prdata,
  output logic                            pready,
  output mck_pkg::cfg_t                   cfg
);
  import mck_pkg::*;

  logic [2:0] idx;
  logic       wr;

  assign idx    = paddr[ADDR_W-1:2];
  assign pready = 1'b1;
  assign wr     = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.dash_units       <= SHORT_W'(3);
      cfg.letter_gap_units <= SHORT_W'(3);
      cfg.word_gap_units   <= DUR_W'(7);
      cfg.line_gap_units   <= DUR_W'(21);
      cfg.active_low       <= 1'b1;
    end else if (wr) begin
      unique case (idx)
        REG_DASH:       cfg.dash_units       <= pwdata[SHORT_W-1:0];
        REG_LETTER_GAP: cfg.letter_gap_units <= pwdata[SHORT_W-1:0];
        REG_WORD_GAP:   cfg.word_gap_units   <= pwdata[DUR_W-1:0];
        REG_LINE_GAP:   cfg.line_gap_units   <= pwdata[DUR_W-1:0];
        REG_ACTIVE_LOW: cfg.active_low       <= pwdata[0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (idx)
      REG_DASH:       prdata = DATA_W'(cfg.dash_units);
      REG_LETTER_GAP: prdata = DATA_W'(cfg.letter_gap_units);
      REG_WORD_GAP:   prdata = DATA_W'(cfg.word_gap_units);
      REG_LINE_GAP:   prdata = DATA_W'(cfg.line_gap_units);
      REG_ACTIVE_LOW: prdata = DATA_W'(cfg.active_low);
      default:        prdata = '0;
    endcase
  end

endmodule
`default_nettype wire

@@ src/mck_seq.sv @@
`default_nettype none
// ---------------------------------------------------------------------------
// mck_seq
// Segment sequencer: classify a character, walk its pattern, emit segments.
// ---------------------------------------------------------------------------
module mck_seq (
  input  wire logic                       clk,
  input  wire logic                       rst,
  input  wire mck_pkg::cfg_t              cfg,
  mck_in_if.sink                          chars,
  mck_out_if.source                       segs,
  output logic                            rom_rd,
  output logic      [mck_pkg::IDX_W-1:0]  rom_addr,
  input  wire mck_pkg::code_t             rom_q
);
  import mck_pkg::*;

  typedef enum logic [1:0] {IDLE, LETTER, GAP} state_t;

  state_t           state;
  logic [3:0]       k;          // segment number within the letter
  logic [DUR_W-1:0] gap_units;
  logic             out_valid;
  logic             out_level;
  logic [DUR_W-1:0] out_dur;
  logic             out_last;

  logic             accept;
  logic             is_letter;
  logic             is_digit;
  logic             is_space;
  logic             is_newline;
  logic             slot_free;
  logic             emit;
  logic [3:0]       last_k;
  logic [2:0]       elem;
  logic [2:0]       shift;
  logic             seg_on;
  logic [DUR_W-1:0] seg_dur;
  logic             seg_last;

  assign chars.ready         = (state == IDLE);
  assign accept              = chars.valid && chars.ready;
  assign segs.valid          = out_valid;
  assign segs.led_level      = out_level;
  assign segs.duration_units = out_dur;
  assign segs.last           = out_last;

  assign is_letter  = (chars.character >= CHAR_LOW_A) && (chars.character <= CHAR_LOW_Z);
  assign is_digit   = (chars.character >= CHAR_ZERO) && (chars.character <= CHAR_NINE);
  assign is_space   = (chars.character == CHAR_SPACE);
  assign is_newline = (chars.character == CHAR_NEWLINE);

  assign rom_rd   = accept && (is_letter || is_digit);
  assign rom_addr = is_letter ? IDX_W'(chars.character - CHAR_LOW_A)
                              : IDX_W'(chars.character - DIGIT_OFFSET);

  assign slot_free = !out_valid || segs.ready;
  assign emit      = ((state == LETTER) || (state == GAP)) && slot_free;

  // Letter walk: even k = element, odd k = inter-element gap, final k = letter gap
  assign last_k = {rom_q.len, 1'b0} - 4'd1;
  assign elem   = k[3:1];
  assign shift  = rom_q.len - 3'd1 - elem;

  always_comb begin
    if (state == GAP) begin
      seg_on   = 1'b0;
      seg_dur  = gap_units;
      seg_last = 1'b1;
    end else if (k == last_k) begin
      seg_on   = 1'b0;
      seg_dur  = DUR_W'(cfg.letter_gap_units);
      seg_last = 1'b1;
    end else if (k[0]) begin
      seg_on   = 1'b0;
      seg_dur  = DUR_W'(1);
      seg_last = 1'b0;
    end else begin
      seg_on   = 1'b1;
      seg_dur  = rom_q.bits[shift] ? DUR_W'(cfg.dash_units) : DUR_W'(1);
      seg_last = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= IDLE;
      k         <= '0;
      out_valid <= 1'b0;
    end else begin
      if (emit) begin
        out_valid <= 1'b1;
      end else if (segs.ready) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        IDLE: begin
          k <= '0;
          if (accept) begin
            priority if (is_letter || is_digit) begin
              state <= LETTER;
            end else if (is_space) begin
              state     <= GAP;
              gap_units <= cfg.word_gap_units;
            end else if (is_newline) begin
              state     <= GAP;
              gap_units <= cfg.line_gap_units;
            end else begin
              // drop any other character
            end
          end
        end
        LETTER, GAP: begin
          if (slot_free) begin
            out_level <= seg_on ^ cfg.active_low;
            out_dur   <= at_least_one(seg_dur);
            out_last  <= seg_last;
            k         <= k + 4'd1;
            if (seg_last) begin
              state <= IDLE;
            end
          end
        end
        default: state <= IDLE;
      endcase
    end
  end

endmodule
`default_nettype wire

@@ verif/morse_code_keyer_test.sv @@
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// morse_code_keyer_test
// Self-checking bench for the Morse keyer. Characters go in on a valid/ready
// channel and LED segments come back on another. The bench holds its own
// Morse table and register copy, and builds the expected segments for each
// accepted character. Each segment that arrives is checked in order against
// those expectations. A directed table comes first, then three random phases
// under different idling, back-pressure and register settings.
// ---------------------------------------------------------------------------
module morse_code_keyer_test;
  import mck_pkg::*;

  localparam int CYCLE_LIMIT     = 400000;
  localparam int SETTLE_CYCLES   = 16;   // time for the longest character to clear the keyer
  localparam int STALL_CYCLES    = 300;
  localparam int ITEMS_PER_PHASE = 60;
  localparam int MAX_REPORTS     = 10;
  localparam int NUM_LETTERS     = 26;
  localparam int NUM_ROWS        = 34;

  // How a directed row gets its expectation
  localparam int PREDICT   = -1;   // work it out from the register copy
  localparam int NO_SEGS   = 0;    // character is ignored
  localparam int ONE_SEG   = 1;    // single segment typed into the row

  // Register indexes with no register behind them
  localparam logic [2:0] REG_SPARE_LOW  = 3'd5;
  localparam logic [2:0] REG_SPARE_HIGH = 3'd7;

  typedef struct packed {
    logic             led_level;
    logic [DUR_W-1:0] duration_units;
    logic             last;
  } seg_t;

  typedef enum logic {ROW_CHAR, ROW_WRITE} row_kind_e;

  typedef struct {
    row_kind_e        kind;
    logic [2:0]       reg_idx;   // only meaningful for register writes
    logic [DATA_W-1:0] value;    // character code or register data
    int               known;
    seg_t             seg;
  } row_t;

  logic              clk = 1'b0;
  logic              rst = 1'b1;
  logic              psel;
  logic              penable;
  logic              pwrite;
  logic [ADDR_W-1:0] paddr;
  logic [DATA_W-1:0] pwdata;
  logic [DATA_W-1:0] prdata;
  logic              pready;

  mck_in_if  char_ch ();
  mck_out_if seg_ch ();

  morse_code_keyer DUT (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .chars   (char_ch),
    .segs    (seg_ch)
  );

  // Morse elements for 'a'..'z' then '0'..'9'
  string morse_pattern [NCODES] = '{
    ".-",    "-...",  "-.-.",  "-..",   ".",     "..-.",  "--.",   "....",
    "..",    ".---",  "-.-",   ".-..",  "--",    "-.",    "---",   ".--.",
    "--.-",  ".-.",   "...",   "-",     "..-",   "...-",  ".--",   "-..-",
    "-.--",  "--..",
    "-----", ".----", "..---", "...--", "....-",
    ".....", "-....", "--...", "---..", "----."
  };

  // Directed stimulus. Rows with a typed answer are those whose answer is
  // plain from the register values alone: one gap segment for space and newline,
  // none for characters the keyer ignores. Everything else goes through the predictor.
  row_t directed_rows [NUM_ROWS] = '{
    // reset timing, both polarities of the field bits
    '{ROW_CHAR,  REG_DASH, DATA_W'(CHAR_SPACE),   ONE_SEG, '{1'b1, 6'd7,  1'b1}},
    '{ROW_CHAR,  REG_DASH, DATA_W'(CHAR_NEWLINE), ONE_SEG, '{1'b1, 6'd21, 1'b1}},
    '{ROW_CHAR,  REG_DASH, DATA_W'("e"),          PREDICT, '0},
    '{ROW_CHAR,  REG_DASH, DATA_W'("a"),          PREDICT, '0},
    '{ROW_CHAR,  REG_DASH, DATA_W'("0"),          PREDICT, '0},
    '{ROW_CHAR,  REG_DASH, DATA_W'("5"),          PREDICT, '0},
    '{ROW_CHAR,  REG_DASH, DATA_W'("9"),          PREDICT, '0},
    // characters outside the table: uppercase, control, top of range, edges
    '{ROW_CHAR,  REG_DASH, DATA_W'("A"),          NO_SEGS, '0},
    '{ROW_CHAR,  REG_DASH, 32'h0000_0000,         NO_SEGS, '0},
    '{ROW_CHAR,  REG_DASH, 32'h0000_00FF,         NO_SEGS, '0},
    '{ROW_CHAR,  REG_DASH, 32'h0000_0060,         NO_SEGS, '0},
    '{ROW_CHAR,  REG_DASH, 32'h0000_007B,         NO_SEGS, '0},
    '{ROW_CHAR,  REG_DASH, 32'h0000_002F,         NO_SEGS, '0},
    '{ROW_CHAR,  REG_DASH, 32'h0000_003A,         NO_SEGS, '0},
    // zero in every timing register, upper data bits set, polarity flipped
    '{ROW_WRITE, REG_DASH,       32'hFFFF_FFF0,   NO_SEGS, '0},
    '{ROW_WRITE, REG_LETTER_GAP, 32'h0000_0000,   NO_SEGS, '0},
    '{ROW_WRITE, REG_WORD_GAP,   32'hFFFF_FFC0,   NO_SEGS, '0},
    '{ROW_WRITE, REG_LINE_GAP,   32'h0000_0000,   NO_SEGS, '0},
    '{ROW_WRITE, REG_ACTIVE_LOW, 32'hFFFF_FFFE,   NO_SEGS, '0},
    '{ROW_CHAR,  REG_DASH, DATA_W'(CHAR_SPACE),   ONE_SEG, '{1'b0, 6'd1, 1'b1}},
    '{ROW_CHAR,  REG_DASH, DATA_W'(CHAR_NEWLINE), ONE_SEG, '{1'b0, 6'd1, 1'b1}},
    '{ROW_CHAR,  REG_DASH, DATA_W'("b"),          PREDICT, '0},
    // largest values, then writes to unused indexes that must change nothing
    '{ROW_WRITE, REG_DASH,       32'd15,          NO_SEGS, '0},
    '{ROW_WRITE, REG_LETTER_GAP, 32'd15,          NO_SEGS, '0},
    '{ROW_WRITE, REG_WORD_GAP,   32'd63,          NO_SEGS, '0},
    '{ROW_WRITE, REG_LINE_GAP,   32'd63,          NO_SEGS, '0},
    '{ROW_WRITE, REG_ACTIVE_LOW, 32'd1,           NO_SEGS, '0},
    '{ROW_WRITE, REG_SPARE_LOW,  32'h0000_0000,   NO_SEGS, '0},
    '{ROW_WRITE, REG_SPARE_HIGH, 32'h0000_0000,   NO_SEGS, '0},
    '{ROW_CHAR,  REG_DASH, DATA_W'(CHAR_SPACE),   ONE_SEG, '{1'b1, 6'd63, 1'b1}},
    '{ROW_CHAR,  REG_DASH, DATA_W'(CHAR_NEWLINE), ONE_SEG, '{1'b1, 6'd63, 1'b1}},
    '{ROW_CHAR,  REG_DASH, DATA_W'("0"),          PREDICT, '0},
    '{ROW_CHAR,  REG_DASH, DATA_W'("q"),          PREDICT, '0},
    '{ROW_CHAR,  REG_DASH, DATA_W'("z"),          PREDICT, '0}
  };

  cfg_t keyer_cfg;         // bench copy of the timing and polarity registers
  seg_t expected_segs[$];  // segments still owed by the keyer, oldest first

  int send_idle_pct;
  int recv_idle_pct;
  int stall_left;
  int cycle_count;
  int seg_count;
  int mismatch_count;

  // Toggle every half period of 8 ns
  always #4 clk = ~clk;

  // -------------------------------------------------------------------------
  // Predictor
  // -------------------------------------------------------------------------

  // Append one segment; zero timing counts as one unit, level follows polarity
  function automatic void queue_segment(input logic on, input logic [DUR_W-1:0] units,
                                        input logic closing);
    seg_t s;
    s.led_level      = on ^ keyer_cfg.active_low;
    s.duration_units = (units == '0) ? DUR_W'(1) : units;
    s.last           = closing;
    expected_segs.push_back(s);
  endfunction

  // Work out every segment that one accepted character should produce
  function automatic void predict_segments(input logic [CHAR_W-1:0] c);
    string pattern;
    int    code;
    if (c == CHAR_SPACE) begin
      queue_segment(1'b0, keyer_cfg.word_gap_units, 1'b1);
      return;
    end
    if (c == CHAR_NEWLINE) begin
      queue_segment(1'b0, keyer_cfg.line_gap_units, 1'b1);
      return;
    end
    if (c >= CHAR_LOW_A && c <= CHAR_LOW_Z) begin
      code = int'(c - CHAR_LOW_A);
    end else if (c >= CHAR_ZERO && c <= CHAR_NINE) begin
      code = NUM_LETTERS + int'(c - CHAR_ZERO);
    end else begin
      return;  // ignored: nothing comes out
    end
    pattern = morse_pattern[code];
    // Mark each element, then one unit off between elements but not after the last
    for (int e = 0; e < pattern.len(); e++) begin
      queue_segment(1'b1, (pattern[e] == "-") ? DUR_W'(keyer_cfg.dash_units) : DUR_W'(1),
                    1'b0);
      if (e + 1 < pattern.len())
        queue_segment(1'b0, DUR_W'(1), 1'b0);
    end
    // Close the character with the letter gap
    queue_segment(1'b0, DUR_W'(keyer_cfg.letter_gap_units), 1'b1);
  endfunction

  // Mirror a register write; unused indexes are dropped just as the keyer drops them
  function automatic void update_config(input logic [2:0] idx, input logic [DATA_W-1:0] data);
    case (idx)
      REG_DASH:       keyer_cfg.dash_units       = data[SHORT_W-1:0];
      REG_LETTER_GAP: keyer_cfg.letter_gap_units = data[SHORT_W-1:0];
      REG_WORD_GAP:   keyer_cfg.word_gap_units   = data[DUR_W-1:0];
      REG_LINE_GAP:   keyer_cfg.line_gap_units   = data[DUR_W-1:0];
      REG_ACTIVE_LOW: keyer_cfg.active_low       = data[0];
      default: ;
    endcase
  endfunction

  // -------------------------------------------------------------------------
  // Stimulus tasks
  // -------------------------------------------------------------------------

  // Setup cycle, then access cycle; the register takes the data at the edge
  // where the access phase meets pready
  task automatic reg_write(input logic [2:0] idx, input logic [DATA_W-1:0] data);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= ADDR_W'({idx, 2'b00});
    pwdata  <= data;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (pready !== 1'b1);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    update_config(idx, data);
  endtask

  // Offer one character, after a random gap, and return at the edge that takes it.
  // Valid stays high on return; the caller either offers the next item or drops it.
  task automatic send_char(input logic [CHAR_W-1:0] c);
    while ($urandom_range(99) < send_idle_pct) begin
      char_ch.valid <= 1'b0;
      @(posedge clk);
    end
    char_ch.valid     <= 1'b1;
    char_ch.character <= c;
    do @(posedge clk); while (char_ch.ready !== 1'b1);
  endtask

  // Drop valid and wait until every owed segment has arrived, then give any
  // ignored character still in flight time to clear the sequencer
  task automatic wait_idle();
    char_ch.valid <= 1'b0;
    while (expected_segs.size() != 0)
      @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Mostly well-formed text; the rest is any code at all
  function automatic logic [CHAR_W-1:0] pick_character();
    int r;
    r = $urandom_range(99);
    if (r < 55)
      return CHAR_LOW_A + CHAR_W'($urandom_range(NUM_LETTERS - 1));
    if (r < 75)
      return CHAR_ZERO + CHAR_W'($urandom_range(9));
    if (r < 83)
      return CHAR_SPACE;
    if (r < 88)
      return CHAR_NEWLINE;
    return CHAR_W'($urandom_range(255));
  endfunction

  // Send random characters until count of them have produced segments
  task automatic send_random(input int count);
    int produced;
    int owed;
    logic [CHAR_W-1:0] c;
    produced = 0;
    while (produced < count) begin
      c = pick_character();
      send_char(c);
      owed = expected_segs.size();
      predict_segments(c);
      if (expected_segs.size() != owed)
        produced++;
    end
  endtask

  // Load every register with random data; the predictor masks it down
  task automatic randomise_config();
    reg_write(REG_DASH,       $urandom());
    reg_write(REG_LETTER_GAP, $urandom());
    reg_write(REG_WORD_GAP,   $urandom());
    reg_write(REG_LINE_GAP,   $urandom());
    reg_write(REG_ACTIVE_LOW, $urandom());
  endtask

  // -------------------------------------------------------------------------
  // Receiver: random ready, or a long hold-off when one is requested
  // -------------------------------------------------------------------------
  always @(posedge clk) begin
    if (stall_left > 0) begin
      stall_left = stall_left - 1;
      seg_ch.ready <= 1'b0;
    end else begin
      seg_ch.ready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  // -------------------------------------------------------------------------
  // Checker: compare each accepted segment with the oldest expectation
  // -------------------------------------------------------------------------
  task automatic note_mismatch(input string text);
    mismatch_count++;
    if (mismatch_count <= MAX_REPORTS)
      $display("%s", text);
  endtask

  always @(posedge clk) begin
    seg_t got;
    seg_t want;
    if (!rst && seg_ch.valid === 1'b1 && seg_ch.ready === 1'b1) begin
      got = '{seg_ch.led_level, seg_ch.duration_units, seg_ch.last};
      if (expected_segs.size() == 0) begin
        note_mismatch($sformatf("segment %0d arrived with nothing owed: level %0b units %0d last %0b",
                                seg_count, got.led_level, got.duration_units, got.last));
      end else begin
        want = expected_segs.pop_front();
        if (got.led_level !== want.led_level || got.duration_units !== want.duration_units ||
            got.last !== want.last)
          note_mismatch($sformatf({"segment %0d: expected level %0b units %0d last %0b, ",
                                   "got level %0b units %0d last %0b"},
                                  seg_count, want.led_level, want.duration_units, want.last,
                                  got.led_level, got.duration_units, got.last));
      end
      seg_count++;
    end
  end

  // Hard stop in case the keyer hangs
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("morse_code_keyer: mismatch");
      $finish;
    end
  end

  // -------------------------------------------------------------------------
  // Main sequence
  // -------------------------------------------------------------------------
  initial begin
    // Drive every input to a known value before the first edge
    psel              = 1'b0;
    penable           = 1'b0;
    pwrite            = 1'b0;
    paddr             = '0;
    pwdata            = '0;
    char_ch.valid     = 1'b0;
    char_ch.character = '0;
    seg_ch.ready      = 1'b0;
    stall_left        = 0;
    cycle_count       = 0;
    seg_count         = 0;
    mismatch_count    = 0;
    keyer_cfg         = '{4'd3, 4'd3, 6'd7, 6'd21, 1'b1};

    // Phase one idling: sender mostly busy, receiver mostly stalling
    send_idle_pct = 24;
    recv_idle_pct = 73;

    // Hold reset at the start, once only, then release it
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Walk the directed table; registers only change once the keyer is quiet
    foreach (directed_rows[i]) begin
      if (directed_rows[i].kind == ROW_WRITE) begin
        wait_idle();
        reg_write(directed_rows[i].reg_idx, directed_rows[i].value);
      end else begin
        send_char(directed_rows[i].value[CHAR_W-1:0]);
        if (directed_rows[i].known == PREDICT)
          predict_segments(directed_rows[i].value[CHAR_W-1:0]);
        else if (directed_rows[i].known == ONE_SEG)
          expected_segs.push_back(directed_rows[i].seg);
      end
    end

    // Random phase one: random registers, slow receiver
    wait_idle();
    randomise_config();
    send_random(ITEMS_PER_PHASE);

    // Random phase two: shortest timing, active-high drive, slow sender.
    // Pause the sender halfway until the keyer has owed nothing for a while.
    wait_idle();
    send_idle_pct = 73;
    recv_idle_pct = 24;
    reg_write(REG_DASH,       32'd1);
    reg_write(REG_LETTER_GAP, 32'd1);
    reg_write(REG_WORD_GAP,   32'd1);
    reg_write(REG_LINE_GAP,   32'd1);
    reg_write(REG_ACTIVE_LOW, 32'd0);
    send_random(ITEMS_PER_PHASE / 2);
    wait_idle();
    send_random(ITEMS_PER_PHASE - ITEMS_PER_PHASE / 2);

    // Random phase three: no idling on either side, but open with a long
    // receiver hold-off so the keyer backs up and refuses characters
    wait_idle();
    send_idle_pct = 0;
    recv_idle_pct = 0;
    randomise_config();
    stall_left = STALL_CYCLES;
    send_random(ITEMS_PER_PHASE);

    // Drain, then allow a few more cycles for anything stray
    char_ch.valid <= 1'b0;
    while (expected_segs.size() != 0)
      @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);

    if (mismatch_count == 0 && expected_segs.size() == 0) begin
      $display("morse_code_keyer: match");
    end else begin
      $display("morse_code_keyer: mismatch");
    end
    $finish;
  end

endmodule

@@ morse_code_keyer.f @@
+incdir+src
src/mck_pkg.sv
src/mck_ifs.sv
src/mck_code_rom.sv
src/mck_cfg_regs.sv
src/mck_seq.sv
src/morse_code_keyer.sv
verif/morse_code_keyer_test.sv
